FILE: hw/rtl/mqtt_receive_ack_keepalive_assert.svh
// Assertion macros for the receive engine.
`ifndef MQTT_RECEIVE_ACK_KEEPALIVE_ASSERT_SVH
`define MQTT_RECEIVE_ACK_KEEPALIVE_ASSERT_SVH
`ifndef SYNTH
`define MQTTRAK_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define MQTTRAK_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MQTTRAK_ASSERT_IMP(label, clk, rstn, ante, cons)
`define MQTTRAK_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: hw/rtl/mqttrak_pkg.sv
package mqttrak_pkg;

    localparam int unsigned MAX_LENGTH_BYTES_DEF = 4;
    localparam int unsigned QUEUE_DEPTH_DEF      = 4;
    localparam logic [15:0] KEEPALIVE_RESET      = 16'd40;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        SEND_NONE = 2'd0,
        SEND_PING = 2'd1,
        SEND_ACK  = 2'd2
    } send_t;

    // packet types (upper nibble of the fixed header)
    localparam logic [3:0] KIND_NONE     = 4'd0;
    localparam logic [3:0] KIND_CONNACK  = 4'd2;
    localparam logic [3:0] KIND_PUBLISH  = 4'd3;
    localparam logic [3:0] KIND_PUBACK   = 4'd4;
    localparam logic [3:0] KIND_PUBREC   = 4'd5;
    localparam logic [3:0] KIND_PUBREL   = 4'd6;
    localparam logic [3:0] KIND_PUBCOMP  = 4'd7;
    localparam logic [3:0] KIND_SUBACK   = 4'd9;
    localparam logic [3:0] KIND_UNSUBACK = 4'd11;
    localparam logic [3:0] KIND_PINGRESP = 4'd13;
    localparam logic [3:0] KIND_RESERVED = 4'd15;

    localparam logic [1:0] QOS_1 = 2'd1;
    localparam logic [1:0] QOS_2 = 2'd2;

    // transmitted bytes
    localparam logic [7:0] BYTE_PUBACK  = 8'h40;
    localparam logic [7:0] BYTE_PUBREC  = 8'h50;
    localparam logic [7:0] BYTE_PUBREL  = 8'h62;
    localparam logic [7:0] BYTE_PUBCOMP = 8'h70;
    localparam logic [7:0] BYTE_ACK_LEN = 8'h02;
    localparam logic [7:0] BYTE_PINGREQ = 8'hC0;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;

    typedef struct packed {
        send_t       send;
        logic [7:0]  ack_type;
        logic [15:0] packet_id;
        logic        connected;
        logic        online;
        logic        keepalive_on;
        logic        publish_done;
    } job_t;

endpackage

FILE: hw/rtl/mqtt_receive_ack_keepalive.sv
// Channel   Ports                         Payload
// s_        s_tvalid s_tready s_tdata     s_tdata: rx_byte; s_tuser: command
//           s_tuser
// m_        m_tvalid m_tready m_tdata     m_tdata: tx_out, flags; m_tuser: tx_valid;
//           m_tuser m_tlast               m_tlast: last
// cfg_      cfg_valid cfg_ready cfg_data  keepalive_seconds
//
// An input item is decoded in the cycle it is accepted; results leave one per cycle
// while m_tready holds. A reply is one beat (nothing sent), two (ping request) or four
// (acknowledgement), so the output beat counter, not the input, sets the sustained rate.
// A job queue of QUEUE_DEPTH entries sits between decode and output; s_tready
// drops only while it is full. Synchronous active-low reset, keepalive resets to 40.
`include "mqtt_receive_ack_keepalive_assert.svh"

module mqtt_receive_ack_keepalive #(
    parameter int unsigned MAX_LENGTH_BYTES = mqttrak_pkg::MAX_LENGTH_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH      = mqttrak_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] tx_out, [8] connected, [9] online,
                                   // [10] keepalive_on, [11] publish_done, [15:12] zero
    output logic        m_tuser,   // [0] tx_valid
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    mqttrak_pkg::job_t front_job;
    mqttrak_pkg::job_t head_job;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic              in_accept;
    logic [7:0]        tx_byte;
    logic [3:0]        flags;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    mqttrak_front #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .in_accept  (in_accept),
        .in_command (s_tuser),
        .in_byte    (s_tdata),
        .job        (front_job)
    );

    mqttrak_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (in_accept),
        .push_job (front_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_job (head_job)
    );

    mqttrak_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .empty        (q_empty),
        .head_job     (head_job),
        .pop          (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_tx_valid (m_tuser),
        .out_tx_byte  (tx_byte),
        .out_last     (m_tlast),
        .out_flags    (flags)
    );

    assign m_tdata = {4'b0000, flags, tx_byte};

    `MQTTRAK_ASSERT_IMP(a_quiet_single, aclk, aresetn, m_tvalid && !m_tuser, m_tlast && (m_tdata[7:0] == 8'h00))
    `MQTTRAK_ASSERT_NEXT(a_accept_queued, aclk, aresetn, s_tvalid && s_tready, !q_empty)
    `MQTTRAK_ASSERT_IMP(a_pop_on_last, aclk, aresetn, q_pop, !q_empty)

endmodule

FILE: hw/rtl/mqttrak_front.sv
module mqttrak_front #(
    parameter int unsigned MAX_LENGTH_BYTES = mqttrak_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic [15:0]        cfg_data,
    input  logic               in_accept,
    input  logic               in_command,
    input  logic [7:0]         in_byte,
    output mqttrak_pkg::job_t  job
);

    logic [15:0]         keepalive_reg;
    mqttrak_pkg::phase_t phase_reg, phase_next;
    logic [3:0]          packet_kind_reg, packet_kind_next;
    logic [1:0]          qos_level_reg, qos_level_next;
    logic [27:0]         remaining_len_reg, remaining_len_next;
    logic [1:0]          len_byte_count_reg, len_byte_count_next;
    logic [27:0]         payload_pos_reg, payload_pos_next;
    logic [15:0]         topic_len_reg, topic_len_next;
    logic [15:0]         packet_id_reg, packet_id_next;
    logic                conn_flag_reg, conn_flag_next;
    logic                online_flag_reg, online_flag_next;
    logic                ping_enable_reg, ping_enable_next;
    logic [1:0]          missed_pings_reg, missed_pings_next;
    logic [15:0]         secs_since_ping_reg, secs_since_ping_next;
    logic                never_pinged_reg, never_pinged_next;

    logic        finish;
    logic        send_ping;
    logic [27:0] len_sum;
    logic [27:0] pos_inc;
    logic [15:0] secs_inc;

    always_comb begin
        phase_next           = phase_reg;
        packet_kind_next     = packet_kind_reg;
        qos_level_next       = qos_level_reg;
        remaining_len_next   = remaining_len_reg;
        len_byte_count_next  = len_byte_count_reg;
        payload_pos_next     = payload_pos_reg;
        topic_len_next       = topic_len_reg;
        packet_id_next       = packet_id_reg;
        conn_flag_next       = conn_flag_reg;
        online_flag_next     = online_flag_reg;
        ping_enable_next     = ping_enable_reg;
        missed_pings_next    = missed_pings_reg;
        secs_since_ping_next = secs_since_ping_reg;
        never_pinged_next    = never_pinged_reg;
        finish    = 1'b0;
        send_ping = 1'b0;
        len_sum   = remaining_len_reg
                  + (28'(in_byte[6:0]) << (5'd7 * 5'(len_byte_count_reg)));
        pos_inc   = payload_pos_reg + 28'd1;
        secs_inc  = (secs_since_ping_reg == 16'hFFFF) ? secs_since_ping_reg
                                                       : secs_since_ping_reg + 16'd1;

        if (in_command) begin
            secs_since_ping_next = secs_inc;
            if (conn_flag_reg && ping_enable_reg
                && (never_pinged_reg || secs_inc >= keepalive_reg)) begin
                secs_since_ping_next = 16'd0;
                never_pinged_next    = 1'b0;
                if (missed_pings_reg > 2'd1) begin
                    online_flag_next  = 1'b0;
                    ping_enable_next  = 1'b0;
                    conn_flag_next    = 1'b0;
                    missed_pings_next = 2'd0;
                    never_pinged_next = 1'b1;
                end else begin
                    send_ping         = 1'b1;
                    missed_pings_next = missed_pings_reg + 2'd1;
                end
            end
        end else begin
            case (phase_reg)
                mqttrak_pkg::PH_LENGTH: begin
                    remaining_len_next = len_sum;
                    if (in_byte[7]
                        && (({1'b0, len_byte_count_reg} + 3'd1) < 3'(MAX_LENGTH_BYTES))) begin
                        len_byte_count_next = len_byte_count_reg + 2'd1;
                    end else if (len_sum == 28'd0) begin
                        finish = 1'b1;
                    end else begin
                        phase_next       = mqttrak_pkg::PH_PAYLOAD;
                        payload_pos_next = 28'd0;
                    end
                end
                mqttrak_pkg::PH_PAYLOAD: begin
                    if (packet_kind_reg == mqttrak_pkg::KIND_PUBLISH) begin
                        if (payload_pos_reg == 28'd0) begin
                            topic_len_next = {in_byte, 8'h00};
                        end else if (payload_pos_reg == 28'd1) begin
                            topic_len_next = {topic_len_reg[15:8], topic_len_reg[7:0] | in_byte};
                        end else if (qos_level_reg != 2'd0
                                     && payload_pos_reg == 28'(topic_len_reg) + 28'd2) begin
                            packet_id_next = {in_byte, 8'h00};
                        end else if (qos_level_reg != 2'd0
                                     && payload_pos_reg == 28'(topic_len_reg) + 28'd3) begin
                            packet_id_next = {packet_id_reg[15:8], packet_id_reg[7:0] | in_byte};
                        end
                    end else begin
                        if (payload_pos_reg == 28'd0) begin
                            packet_id_next = {in_byte, 8'h00};
                        end else if (payload_pos_reg == 28'd1) begin
                            packet_id_next = {packet_id_reg[15:8], packet_id_reg[7:0] | in_byte};
                        end
                    end
                    payload_pos_next = pos_inc;
                    if (pos_inc >= remaining_len_reg) begin
                        finish = 1'b1;
                    end
                end
                default: begin
                    if (in_byte[7:4] != mqttrak_pkg::KIND_NONE
                        && in_byte[7:4] != mqttrak_pkg::KIND_RESERVED) begin
                        packet_kind_next    = in_byte[7:4];
                        qos_level_next      = in_byte[2:1];
                        remaining_len_next  = 28'd0;
                        len_byte_count_next = 2'd0;
                        payload_pos_next    = 28'd0;
                        topic_len_next      = 16'd0;
                        packet_id_next      = 16'd0;
                        phase_next          = mqttrak_pkg::PH_LENGTH;
                    end else begin
                        phase_next = mqttrak_pkg::PH_HEADER;
                    end
                end
            endcase

            if (finish) begin
                phase_next = mqttrak_pkg::PH_HEADER;
                case (packet_kind_reg)
                    mqttrak_pkg::KIND_CONNACK: begin
                        conn_flag_next = 1'b1;
                    end
                    mqttrak_pkg::KIND_PUBACK, mqttrak_pkg::KIND_PUBCOMP,
                    mqttrak_pkg::KIND_SUBACK, mqttrak_pkg::KIND_UNSUBACK: begin
                        ping_enable_next = 1'b1;
                    end
                    mqttrak_pkg::KIND_PINGRESP: begin
                        online_flag_next  = 1'b1;
                        missed_pings_next = 2'd0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // job for the reply side
    always_comb begin
        job              = '0;
        job.send         = mqttrak_pkg::SEND_NONE;
        job.packet_id    = packet_id_next;
        job.connected    = conn_flag_next;
        job.online       = online_flag_next;
        job.keepalive_on = ping_enable_next;
        if (send_ping) begin
            job.send = mqttrak_pkg::SEND_PING;
        end
        if (finish) begin
            case (packet_kind_reg)
                mqttrak_pkg::KIND_PUBLISH: begin
                    job.publish_done = 1'b1;
                    if (qos_level_reg == mqttrak_pkg::QOS_1) begin
                        job.send     = mqttrak_pkg::SEND_ACK;
                        job.ack_type = mqttrak_pkg::BYTE_PUBACK;
                    end else if (qos_level_reg == mqttrak_pkg::QOS_2) begin
                        job.send     = mqttrak_pkg::SEND_ACK;
                        job.ack_type = mqttrak_pkg::BYTE_PUBREC;
                    end
                end
                mqttrak_pkg::KIND_PUBREC: begin
                    job.send     = mqttrak_pkg::SEND_ACK;
                    job.ack_type = mqttrak_pkg::BYTE_PUBREL;
                end
                mqttrak_pkg::KIND_PUBREL: begin
                    job.send     = mqttrak_pkg::SEND_ACK;
                    job.ack_type = mqttrak_pkg::BYTE_PUBCOMP;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keepalive_reg       <= mqttrak_pkg::KEEPALIVE_RESET;
            phase_reg           <= mqttrak_pkg::PH_HEADER;
            packet_kind_reg     <= 4'd0;
            qos_level_reg       <= 2'd0;
            remaining_len_reg   <= 28'd0;
            len_byte_count_reg  <= 2'd0;
            payload_pos_reg     <= 28'd0;
            topic_len_reg       <= 16'd0;
            packet_id_reg       <= 16'd0;
            conn_flag_reg       <= 1'b0;
            online_flag_reg     <= 1'b0;
            ping_enable_reg     <= 1'b0;
            missed_pings_reg    <= 2'd0;
            secs_since_ping_reg <= 16'd0;
            never_pinged_reg    <= 1'b1;
        end else begin
            if (cfg_valid) begin
                keepalive_reg <= cfg_data;
            end
            if (in_accept) begin
                phase_reg           <= phase_next;
                packet_kind_reg     <= packet_kind_next;
                qos_level_reg       <= qos_level_next;
                remaining_len_reg   <= remaining_len_next;
                len_byte_count_reg  <= len_byte_count_next;
                payload_pos_reg     <= payload_pos_next;
                topic_len_reg       <= topic_len_next;
                packet_id_reg       <= packet_id_next;
                conn_flag_reg       <= conn_flag_next;
                online_flag_reg     <= online_flag_next;
                ping_enable_reg     <= ping_enable_next;
                missed_pings_reg    <= missed_pings_next;
                secs_since_ping_reg <= secs_since_ping_next;
                never_pinged_reg    <= never_pinged_next;
            end
        end
    end

endmodule

FILE: hw/rtl/mqttrak_queue.sv
module mqttrak_queue #(
    parameter int unsigned QUEUE_DEPTH = mqttrak_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  mqttrak_pkg::job_t  push_job,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output mqttrak_pkg::job_t  head_job
);

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    mqttrak_pkg::job_t mem [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: hw/rtl/mqttrak_back.sv
module mqttrak_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               empty,
    input  mqttrak_pkg::job_t  head_job,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_tx_valid,
    output logic [7:0]         out_tx_byte,
    output logic               out_last,
    output logic [3:0]         out_flags
);

    logic       out_valid_reg, out_valid_next;
    logic       tx_valid_reg, tx_valid_next;
    logic [7:0] tx_byte_reg, tx_byte_next;
    logic       last_reg, last_next;
    logic [3:0] flags_reg, flags_next;
    logic [1:0] beat_reg, beat_next;
    logic [1:0] last_beat;
    logic       load;

    assign load = !out_valid_reg || out_ready;

    always_comb begin
        case (head_job.send)
            mqttrak_pkg::SEND_ACK:  last_beat = 2'd3;
            mqttrak_pkg::SEND_PING: last_beat = 2'd1;
            default:                last_beat = 2'd0;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        beat_next      = beat_reg;
        pop            = 1'b0;
        if (load) begin
            out_valid_next = !empty;
            if (!empty) begin
                if (beat_reg == last_beat) begin
                    pop       = 1'b1;
                    beat_next = 2'd0;
                end else begin
                    beat_next = beat_reg + 2'd1;
                end
            end
        end
    end

    always_comb begin
        tx_valid_next = (head_job.send != mqttrak_pkg::SEND_NONE);
        last_next     = (beat_reg == last_beat);
        flags_next    = {head_job.publish_done, head_job.keepalive_on,
                         head_job.online, head_job.connected};
        tx_byte_next  = mqttrak_pkg::BYTE_ZERO;
        case (head_job.send)
            mqttrak_pkg::SEND_ACK: begin
                case (beat_reg)
                    2'd0:    tx_byte_next = head_job.ack_type;
                    2'd1:    tx_byte_next = mqttrak_pkg::BYTE_ACK_LEN;
                    2'd2:    tx_byte_next = head_job.packet_id[15:8];
                    default: tx_byte_next = head_job.packet_id[7:0];
                endcase
            end
            mqttrak_pkg::SEND_PING: begin
                tx_byte_next = (beat_reg == 2'd0) ? mqttrak_pkg::BYTE_PINGREQ
                                                  : mqttrak_pkg::BYTE_ZERO;
            end
            default: begin
                tx_byte_next = mqttrak_pkg::BYTE_ZERO;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            beat_reg      <= 2'd0;
        end else begin
            out_valid_reg <= out_valid_next;
            beat_reg      <= beat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && !empty) begin
            tx_valid_reg <= tx_valid_next;
            tx_byte_reg  <= tx_byte_next;
            last_reg     <= last_next;
            flags_reg    <= flags_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_tx_valid = tx_valid_reg;
    assign out_tx_byte  = tx_byte_reg;
    assign out_last     = last_reg;
    assign out_flags    = flags_reg;

endmodule

FILE: tb/sv/mqtt_receive_ack_keepalive_checker.sv
`timescale 1ns / 100ps

module mqtt_receive_ack_keepalive_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] command
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] tx_out, [8] connected, [9] online,
                                   // [10] keepalive_on, [11] publish_done, [15:12] zero
    input  logic        m_tuser,   // [0] tx_valid
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);
    import mqttrak_pkg::*;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_out;
        logic       last;
        logic       connected;
        logic       online;
        logic       keepalive_on;
        logic       publish_done;
    } reply_t;

    logic [15:0] keepalive_secs;
    phase_t      rx_phase;
    logic [3:0]  pkt_kind;
    logic [1:0]  pkt_qos;
    logic [27:0] rem_len;
    int unsigned len_idx;
    logic [27:0] pay_pos;
    logic [15:0] topic_len;
    logic [15:0] pkt_id;
    logic        conn_flag;
    logic        online_flag;
    logic        ping_en;
    logic [1:0]  missed;
    logic [15:0] secs;
    logic        never_pinged;
    logic        pub_pulse;
    logic [7:0]  tx_bytes[$];
    reply_t      reply_q[$];
    int          err_cnt = 0;

    function automatic void push_tx(logic [7:0] b);
        if (tx_bytes.size() < 4) tx_bytes.push_back(b);
    endfunction

    function automatic void push_ack(logic [7:0] first);
        push_tx(first);
        push_tx(BYTE_ACK_LEN);
        push_tx(pkt_id[15:8]);
        push_tx(pkt_id[7:0]);
    endfunction

    function automatic void end_packet();
        rx_phase = PH_HEADER;
        case (pkt_kind)
            KIND_CONNACK: conn_flag = 1'b1;
            KIND_PUBLISH: begin
                if (pkt_qos == QOS_1) push_ack(BYTE_PUBACK);
                else if (pkt_qos == QOS_2) push_ack(BYTE_PUBREC);
                pub_pulse = 1'b1;
            end
            KIND_PUBREC: push_ack(BYTE_PUBREL);
            KIND_PUBREL: push_ack(BYTE_PUBCOMP);
            KIND_PUBACK, KIND_PUBCOMP, KIND_SUBACK, KIND_UNSUBACK: ping_en = 1'b1;
            KIND_PINGRESP: begin
                online_flag = 1'b1;
                missed = 2'd0;
            end
            default: ;
        endcase
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        logic [27:0] pos;
        case (rx_phase)
            PH_LENGTH: begin
                rem_len = rem_len + (28'(b[6:0]) << (7 * len_idx));
                if (b[7] && len_idx + 1 < MAX_LENGTH_BYTES_DEF) begin
                    len_idx = len_idx + 1;
                end else if (rem_len == 28'd0) begin
                    end_packet();
                end else begin
                    rx_phase = PH_PAYLOAD;
                    pay_pos = 28'd0;
                end
            end
            PH_PAYLOAD: begin
                pos = pay_pos;
                if (pkt_kind == KIND_PUBLISH) begin
                    if (pos == 28'd0) topic_len = {b, 8'h00};
                    else if (pos == 28'd1) topic_len[7:0] = topic_len[7:0] | b;
                    else if (pkt_qos != 2'd0 && pos == 28'(topic_len) + 28'd2)
                        pkt_id = {b, 8'h00};
                    else if (pkt_qos != 2'd0 && pos == 28'(topic_len) + 28'd3)
                        pkt_id[7:0] = pkt_id[7:0] | b;
                end else begin
                    if (pos == 28'd0) pkt_id = {b, 8'h00};
                    else if (pos == 28'd1) pkt_id[7:0] = pkt_id[7:0] | b;
                end
                pay_pos = pos + 28'd1;
                if (pay_pos >= rem_len) end_packet();
            end
            default: begin
                // header byte; unused phase code lands here too
                if (b[7:4] != KIND_NONE && b[7:4] != KIND_RESERVED) begin
                    pkt_kind = b[7:4];
                    pkt_qos = b[2:1];
                    rem_len = 28'd0;
                    len_idx = 0;
                    pay_pos = 28'd0;
                    topic_len = 16'd0;
                    pkt_id = 16'd0;
                    rx_phase = PH_LENGTH;
                end else begin
                    rx_phase = PH_HEADER;
                end
            end
        endcase
    endfunction

    function automatic void tick_second();
        if (secs != 16'hFFFF) secs = secs + 16'd1;
        if (conn_flag && ping_en && (never_pinged || secs >= keepalive_secs)) begin
            secs = 16'd0;
            never_pinged = 1'b0;
            if (missed > 2'd1) begin
                // two pings went unanswered
                online_flag = 1'b0;
                ping_en = 1'b0;
                conn_flag = 1'b0;
                missed = 2'd0;
                never_pinged = 1'b1;
            end else begin
                push_tx(BYTE_PINGREQ);
                push_tx(BYTE_ZERO);
                missed = missed + 2'd1;
            end
        end
    endfunction

    function automatic void predict_replies(logic cmd, logic [7:0] b);
        reply_t r;
        int n;
        int k;
        tx_bytes.delete();
        pub_pulse = 1'b0;
        if (cmd) tick_second();
        else decode_byte(b);
        n = (tx_bytes.size() > 0) ? tx_bytes.size() : 1;
        for (k = 0; k < n; k++) begin
            r.tx_valid = (tx_bytes.size() > 0);
            r.tx_out = r.tx_valid ? tx_bytes[k] : BYTE_ZERO;
            r.last = (k == n - 1);
            r.connected = conn_flag;
            r.online = online_flag;
            r.keepalive_on = ping_en;
            r.publish_done = pub_pulse;
            reply_q.push_back(r);
        end
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            keepalive_secs = KEEPALIVE_RESET;
            rx_phase = PH_HEADER;
            pkt_kind = KIND_NONE;
            pkt_qos = 2'd0;
            rem_len = 28'd0;
            len_idx = 0;
            pay_pos = 28'd0;
            topic_len = 16'd0;
            pkt_id = 16'd0;
            conn_flag = 1'b0;
            online_flag = 1'b0;
            ping_en = 1'b0;
            missed = 2'd0;
            secs = 16'd0;
            never_pinged = 1'b1;
            pub_pulse = 1'b0;
            reply_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) keepalive_secs = cfg_data;
            // input first: a result leaving in the same cycle is older and stays in order
            if (s_tvalid && s_tready) predict_replies(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (reply_q.size() == 0) begin
                    $error("result with no item pending: tx_out %0h", m_tdata[7:0]);
                    err_cnt++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("tx_valid", 8'(want.tx_valid), 8'(m_tuser));
                    check_field("tx_out", want.tx_out, m_tdata[7:0]);
                    check_field("last", 8'(want.last), 8'(m_tlast));
                    check_field("connected", 8'(want.connected), 8'(m_tdata[8]));
                    check_field("online", 8'(want.online), 8'(m_tdata[9]));
                    check_field("keepalive_on", 8'(want.keepalive_on), 8'(m_tdata[10]));
                    check_field("publish_done", 8'(want.publish_done), 8'(m_tdata[11]));
                    check_field("tdata_pad", 8'h00, 8'(m_tdata[15:12]));
                end
            end
        end
        mismatches <= err_cnt;
        outstanding <= reply_q.size();
    end

endmodule

FILE: tb/sv/mqtt_receive_ack_keepalive_tb.sv
`timescale 1ns / 100ps

module mqtt_receive_ack_keepalive_tb;
    import mqttrak_pkg::*;

    localparam int ITEM_TARGET = 400;
    localparam int STALL_LIMIT = 2000;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = 16'd0;

    int         mismatches;
    int         outstanding;
    int         idle_pct    = 0;
    int         stall_pct   = 0;
    int         items_sent  = 0;
    int         quiet_cycles = 0;
    logic [7:0] body_q[$];

    mqtt_receive_ack_keepalive uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    mqtt_receive_ack_keepalive_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] b);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= b;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(1'b1, 8'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(1'b0, b);
    endtask

    // header, remaining length (optionally stretched with empty groups), then body_q
    task automatic send_frame(input logic [7:0] hdr, input bit pad);
        int rem;
        int n;
        logic [7:0] g;
        logic [7:0] grp[$];
        rem = body_q.size();
        do begin
            g = 8'(rem & 127);
            rem = rem >> 7;
            if (rem != 0) g[7] = 1'b1;
            grp.push_back(g);
        end while (rem != 0);
        if (pad) begin
            n = $urandom_range(MAX_LENGTH_BYTES_DEF, grp.size());
            while (grp.size() < n) begin
                g = grp.pop_back();
                g[7] = 1'b1;
                grp.push_back(g);
                grp.push_back(8'h00);
            end
            if (grp.size() == MAX_LENGTH_BYTES_DEF && $urandom_range(1) == 1) begin
                g = grp.pop_back();
                g[7] = 1'b1;
                grp.push_back(g);
            end
        end
        send_byte(hdr);
        while (grp.size() > 0) send_byte(grp.pop_front());
        while (body_q.size() > 0) send_byte(body_q.pop_front());
    endtask

    task automatic send_publish(input logic [1:0] qos, input int tlen, input int topic_n,
                                input int extra, input bit pad, input int cut);
        body_q.delete();
        body_q.push_back(8'(tlen >> 8));
        body_q.push_back(8'(tlen));
        repeat (topic_n) body_q.push_back(8'($urandom));
        if (qos != 2'd0) begin
            body_q.push_back(8'($urandom));
            body_q.push_back(8'($urandom));
        end
        repeat (extra) body_q.push_back(8'($urandom));
        repeat (cut) if (body_q.size() > 0) void'(body_q.pop_back());
        send_frame({KIND_PUBLISH, 1'($urandom), qos, 1'($urandom)}, pad);
    endtask

    task automatic send_body_frame(input logic [3:0] kind, input int n);
        body_q.delete();
        repeat (n) body_q.push_back(8'($urandom));
        send_frame({kind, 4'($urandom)}, ($urandom_range(3) == 0));
    endtask

    task automatic send_random_unit();
        int pick;
        int n;
        logic [3:0] kind;
        pick = $urandom_range(99);
        n = $urandom_range(4);
        if (pick < 18) begin
            repeat ($urandom_range(3, 1)) send_tick();
        end else if (pick < 23) begin
            send_byte({($urandom_range(1) == 1) ? KIND_RESERVED : KIND_NONE, 4'($urandom)});
        end else if (pick < 43) begin
            if ($urandom_range(9) == 0)
                send_publish(2'($urandom), $urandom_range(65535), n, $urandom_range(2),
                             ($urandom_range(3) == 0), $urandom_range(4));
            else
                send_publish(2'($urandom), n, n, $urandom_range(3), ($urandom_range(3) == 0), 0);
        end else if (pick < 53) begin
            send_body_frame(KIND_CONNACK, 2);
        end else if (pick < 68) begin
            case ($urandom_range(3))
                0: kind = KIND_PUBACK;
                1: kind = KIND_PUBCOMP;
                2: kind = KIND_SUBACK;
                default: kind = KIND_UNSUBACK;
            endcase
            send_body_frame(kind, $urandom_range(3, 2));
        end else if (pick < 78) begin
            send_body_frame(($urandom_range(1) == 1) ? KIND_PUBREC : KIND_PUBREL, 2);
        end else if (pick < 86) begin
            send_body_frame(KIND_PINGRESP, 0);
        end else begin
            kind = 4'($urandom_range(14, 1));
            if ($urandom_range(24) == 0) send_body_frame(kind, $urandom_range(140, 128));
            else send_body_frame(kind, $urandom_range(5));
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_keepalive(input logic [15:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int p;
        int goal;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reserved and zero packet types are dropped
        send_byte({KIND_NONE, 4'hF});
        send_byte({KIND_RESERVED, 4'hA});
        body_q.delete();
        send_frame({KIND_CONNACK, 4'h0}, 1'b0);
        body_q = '{8'h00, 8'h00, 8'h12, 8'h34};
        send_frame({KIND_PUBLISH, 4'h2}, 1'b0);
        body_q.delete();
        send_frame({KIND_SUBACK, 4'h0}, 1'b0);
        write_keepalive(16'd1);
        // ping, ping, then the session drops
        repeat (3) send_tick();
        body_q = '{8'hFF, 8'hFF};
        send_frame({KIND_PUBREC, 4'h0}, 1'b0);
        body_q = '{8'hAB, 8'hCD};
        send_frame({KIND_PUBREL, 4'h2}, 1'b0);
        // qos 2 with empty payload, then qos 3
        body_q.delete();
        send_frame({KIND_PUBLISH, 4'h4}, 1'b0);
        send_frame({KIND_PUBLISH, 4'hF}, 1'b0);
        // four length bytes, the last still flagged as more
        send_byte({KIND_PINGRESP, 4'h0});
        send_byte(8'h81);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'hFF);

        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                    write_keepalive(16'd3);
                end
                1: begin
                    idle_pct = 52;
                    stall_pct = 0;
                    write_keepalive(16'hFFFF);
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 52;
                    write_keepalive(16'($urandom_range(6, 2)));
                end
                default: begin
                    idle_pct = 17;
                    stall_pct = 17;
                    write_keepalive(16'd2);
                end
            endcase
            goal = items_sent + ITEM_TARGET / 4;
            while (items_sent < goal) send_random_unit();
        end

        wait_drained();
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
